// ----- hdl/cr_pkg.sv -----
// Shared types and constants for the Catmull-Rom curve point evaluator.
// No dependencies; imported by the top level and its port checker.
`default_nettype none

package cr_pkg;

  localparam int COORD_W   = 32;  // signed Q16.16 coordinate
  localparam int PARAM_W   = 17;  // unsigned Q1.16 curve parameter, 1.0 included
  localparam int FRAC_W    = 16;  // fraction of the local parameter
  localparam int IDX_IN_W  = 4;   // width of point_index and last_point_index
  localparam int SEG_W     = 5;   // segment index with room for +2
  localparam int SCALED_W  = PARAM_W + IDX_IN_W;
  localparam int NUM_AXES  = 3;

  // Coefficient and Horner partial-result widths (signed)
  localparam int A_W  = 36;
  localparam int C_W  = 34;
  localparam int D_W  = 33;
  localparam int R1_W = 38;
  localparam int R2_W = 38;
  localparam int R3_W = 39;

  localparam logic [PARAM_W-1:0] ONE_Q16 = PARAM_W'(65536);

  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_EVAL  = 1'b1;

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
  } point_t;

endpackage

`default_nettype wire

// ----- hdl/catmull_rom_curve_point.sv -----
// Uniform Catmull-Rom curve point evaluator: write items fill the control point
// table, evaluate items produce one saturated 3D point. Uses cr_pkg.
// Throughput: one word per cycle unless out_ready stalls the output; stages are the table
// read at acceptance (two copies, two read ports each), coefficient and three Horner stages.
// Reset: synchronous, active low; clears pipeline valids, sets last index to 1.
// The point table has no reset; entries are defined once written.
`default_nettype none

module catmull_rom_curve_point #(
  parameter int MAX_POINTS = 16
) (
  input  wire                           clk,
  input  wire                           rst_n,
  // configuration
  input  wire                           cfg_valid,
  output logic                          cfg_ready,
  input  wire [cr_pkg::IDX_IN_W-1:0]    cfg_last_point_index,
  // input words
  input  wire                           in_valid,
  output logic                          in_ready,
  input  wire                           in_action,
  input  wire [cr_pkg::IDX_IN_W-1:0]    in_point_index,
  input  wire signed [cr_pkg::COORD_W-1:0] in_point_x,
  input  wire signed [cr_pkg::COORD_W-1:0] in_point_y,
  input  wire signed [cr_pkg::COORD_W-1:0] in_point_z,
  input  wire [cr_pkg::PARAM_W-1:0]     in_curve_param,
  // result words
  output logic                          out_valid,
  input  wire                           out_ready,
  output logic signed [cr_pkg::COORD_W-1:0] out_curve_x,
  output logic signed [cr_pkg::COORD_W-1:0] out_curve_y,
  output logic signed [cr_pkg::COORD_W-1:0] out_curve_z
);

  import cr_pkg::*;

  localparam int IW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int S1_W = A_W + FRAC_W + 2;
  localparam int S2_W = R1_W + FRAC_W + 2;
  localparam int S3_W = R2_W + FRAC_W + 2;
  localparam logic [IDX_IN_W-1:0] LAST_MAX =
    (MAX_POINTS - 1 > 15) ? IDX_IN_W'(15) : IDX_IN_W'(MAX_POINTS - 1);

  // Two copies of the table so four points can be read per cycle
  point_t mem_a [MAX_POINTS];
  point_t mem_b [MAX_POINTS];

  logic [IDX_IN_W-1:0] last_r;
  logic v1_r, v2_r, v3_r, v4_r, out_valid_r;
  logic rdy1, rdy2, rdy3, rdy4, out_rdy;
  logic wr_en, ev_en;

  logic [IDX_IN_W-1:0] last_eff;
  logic [PARAM_W-1:0]  t_c;
  logic [SCALED_W-1:0] scaled;
  logic [SEG_W-1:0]    seg, i0, i1, i2, i3, seg_p1, seg_p2, last5;
  logic [FRAC_W-1:0]   u0;

  point_t p0_r, p1_r, p2_r, p3_r;
  logic [FRAC_W-1:0] u1_r, u2_r, u3_r, u4_r;

  coord_t res_nxt [NUM_AXES];

  // ---------------- control ----------------
  assign cfg_ready = 1'b1;
  assign out_rdy   = !out_valid_r || out_ready;
  assign rdy4      = !v4_r || out_rdy;
  assign rdy3      = !v3_r || rdy4;
  assign rdy2      = !v2_r || rdy3;
  assign rdy1      = !v1_r || rdy2;
  assign in_ready  = rdy1;
  assign out_valid = out_valid_r;

  assign wr_en = in_valid && in_ready && (in_action == ACT_WRITE) &&
                 (int'(in_point_index) < MAX_POINTS);
  assign ev_en = in_valid && in_ready && (in_action == ACT_EVAL);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_r      <= IDX_IN_W'(1);
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        last_r <= cfg_last_point_index;
      end
      if (rdy1) v1_r <= ev_en;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (rdy4) v4_r <= v3_r;
      if (out_rdy) out_valid_r <= v4_r;
    end
  end

  // ---------------- segment and neighbour indices ----------------
  always_comb begin
    last_eff = (last_r > LAST_MAX) ? LAST_MAX : last_r;
    t_c      = (in_curve_param > ONE_Q16) ? ONE_Q16 : in_curve_param;
    scaled   = SCALED_W'(t_c) * SCALED_W'(last_eff);
    seg      = scaled[SCALED_W-1:FRAC_W];
    u0       = scaled[FRAC_W-1:0];
    last5    = SEG_W'(last_eff);
    seg_p1   = seg + SEG_W'(1);
    seg_p2   = seg + SEG_W'(2);
    i1       = seg;
    i0       = (seg == '0) ? '0 : seg - SEG_W'(1);
    i2       = (seg_p1 > last5) ? last5 : seg_p1;
    i3       = (seg_p2 > last5) ? last5 : seg_p2;
  end

  // ---------------- table ----------------
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_a[IW'(in_point_index)] <= '{x: in_point_x, y: in_point_y, z: in_point_z};
      mem_b[IW'(in_point_index)] <= '{x: in_point_x, y: in_point_y, z: in_point_z};
    end
    if (ev_en) begin
      p0_r <= mem_a[IW'(i0)];
      p1_r <= mem_a[IW'(i1)];
      p2_r <= mem_b[IW'(i2)];
      p3_r <= mem_b[IW'(i3)];
      u1_r <= u0;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy2) u2_r <= u1_r;
    if (rdy3) u3_r <= u2_r;
    if (rdy4) u4_r <= u3_r;
  end

  // ---------------- per-axis Horner pipeline ----------------
  for (genvar k = 0; k < NUM_AXES; k++) begin : g_axis
    logic signed [COORD_W-1:0] q0, q1, q2, q3;
    logic signed [A_W-1:0]  a_r, b_r, a_nxt, b_nxt;
    logic signed [C_W-1:0]  c2_r, c3_r, c4_r, c_nxt;
    logic signed [D_W-1:0]  d2_r, d3_r, d4_r, d_nxt;
    logic signed [R1_W-1:0] r1_r, r1_nxt;
    logic signed [R2_W-1:0] r2_r, r2_nxt;
    logic signed [R3_W-1:0] r3;
    logic signed [S1_W-1:0] sum1;
    logic signed [S2_W-1:0] sum2;
    logic signed [S3_W-1:0] sum3;

    always_comb begin
      case (k)
        0: begin
          q0 = p0_r.x; q1 = p1_r.x; q2 = p2_r.x; q3 = p3_r.x;
        end
        1: begin
          q0 = p0_r.y; q1 = p1_r.y; q2 = p2_r.y; q3 = p3_r.y;
        end
        default: begin
          q0 = p0_r.z; q1 = p1_r.z; q2 = p2_r.z; q3 = p3_r.z;
        end
      endcase
      a_nxt = -A_W'(q0) + A_W'(3) * A_W'(q1) - A_W'(3) * A_W'(q2) + A_W'(q3);
      b_nxt = A_W'(2) * A_W'(q0) - A_W'(5) * A_W'(q1) + A_W'(4) * A_W'(q2) - A_W'(q3);
      c_nxt = C_W'(q2) - C_W'(q0);
      d_nxt = D_W'(q1) <<< 1;
    end

    // r1 = rnd(a*u + b*2^16, 16)
    always_comb begin
      sum1 = S1_W'(a_r) * S1_W'($signed({1'b0, u2_r})) + (S1_W'(b_r) <<< FRAC_W)
             + S1_W'(1 <<< (FRAC_W - 1));
      r1_nxt = R1_W'(sum1 >>> FRAC_W);
    end

    // r2 = rnd(r1*u + c*2^16, 16)
    always_comb begin
      sum2 = S2_W'(r1_r) * S2_W'($signed({1'b0, u3_r})) + (S2_W'(c3_r) <<< FRAC_W)
             + S2_W'(1 <<< (FRAC_W - 1));
      r2_nxt = R2_W'(sum2 >>> FRAC_W);
    end

    // r3 = rnd(r2*u + d*2^16, 17), the extra bit halves; then saturate
    always_comb begin
      sum3 = S3_W'(r2_r) * S3_W'($signed({1'b0, u4_r})) + (S3_W'(d4_r) <<< FRAC_W)
             + S3_W'(1 <<< FRAC_W);
      r3 = R3_W'(sum3 >>> (FRAC_W + 1));
      if (r3[R3_W-1:COORD_W-1] == '0 || r3[R3_W-1:COORD_W-1] == '1) begin
        res_nxt[k] = r3[COORD_W-1:0];
      end else if (r3[R3_W-1]) begin
        res_nxt[k] = {1'b1, {(COORD_W-1){1'b0}}};
      end else begin
        res_nxt[k] = {1'b0, {(COORD_W-1){1'b1}}};
      end
    end

    always_ff @(posedge clk) begin
      if (rdy2) begin
        a_r  <= a_nxt;
        b_r  <= b_nxt;
        c2_r <= c_nxt;
        d2_r <= d_nxt;
      end
      if (rdy3) begin
        r1_r <= r1_nxt;
        c3_r <= c2_r;
        d3_r <= d2_r;
      end
      if (rdy4) begin
        r2_r <= r2_nxt;
        c4_r <= c3_r;
        d4_r <= d3_r;
      end
    end
  end

  // ---------------- output register ----------------
  always_ff @(posedge clk) begin
    if (out_rdy && v4_r) begin
      out_curve_x <= res_nxt[0];
      out_curve_y <= res_nxt[1];
      out_curve_z <= res_nxt[2];
    end
  end

endmodule

`default_nettype wire

// ----- hdl/cr_checker.sv -----
// Port-level checker for catmull_rom_curve_point, attached by bind.
// Depends on cr_pkg for field widths.
`default_nettype none

module cr_checker (
  input wire                               clk,
  input wire                               rst_n,
  input wire                               cfg_ready,
  input wire                               in_ready,
  input wire                               out_valid,
  input wire                               out_ready,
  input wire signed [cr_pkg::COORD_W-1:0]  out_curve_x,
  input wire signed [cr_pkg::COORD_W-1:0]  out_curve_y,
  input wire signed [cr_pkg::COORD_W-1:0]  out_curve_z
);

  import cr_pkg::*;

  // drop out_valid on the edge following reset
  a_reset_clears: assert property (@(posedge clk) $past(!rst_n) |-> !out_valid)
    else $error("out_valid high after reset");

  // an empty output stage frees the whole pipeline chain
  a_empty_accepts: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("in_ready low with output stage empty");

  a_cfg_always: assert property (@(posedge clk) disable iff (!rst_n) cfg_ready)
    else $error("configuration port stalled");

  // hold a stalled result word
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_curve_x) &&
    $stable(out_curve_y) && $stable(out_curve_z))
    else $error("stalled result word changed");

endmodule

bind catmull_rom_curve_point cr_checker u_cr_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .cfg_ready   (cfg_ready),
  .in_ready    (in_ready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .out_curve_x (out_curve_x),
  .out_curve_y (out_curve_y),
  .out_curve_z (out_curve_z)
);

`default_nettype wire

// ----- bench/tb_top.sv -----
// Self-checking bench for catmull_rom_curve_point: loads the control point table,
// evaluates the curve under several last-index settings and compares each word.
// Depends on cr_pkg and the catmull_rom_curve_point top level only.
`timescale 1ns / 100ps

module tb_top;
  import cr_pkg::*;

  localparam int NUM_SLOTS  = 16;
  localparam int DRAIN_WAIT = 10;

  logic                clk;
  logic                rst_n;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [IDX_IN_W-1:0] cfg_last_point_index;
  logic                in_valid;
  logic                in_ready;
  logic                in_action;
  logic [IDX_IN_W-1:0] in_point_index;
  coord_t              in_point_x;
  coord_t              in_point_y;
  coord_t              in_point_z;
  logic [PARAM_W-1:0]  in_curve_param;
  logic                out_valid;
  logic                out_ready;
  coord_t              out_curve_x;
  coord_t              out_curve_y;
  coord_t              out_curve_z;

  // predictor state
  point_t              point_table [NUM_SLOTS];
  logic [IDX_IN_W-1:0] last_index;
  point_t              expected_points [$];

  int unsigned         mismatch_count;
  int unsigned         send_idle_pct;
  int unsigned         recv_idle_pct;

  catmull_rom_curve_point dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_valid            (cfg_valid),
    .cfg_ready            (cfg_ready),
    .cfg_last_point_index (cfg_last_point_index),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_action            (in_action),
    .in_point_index       (in_point_index),
    .in_point_x           (in_point_x),
    .in_point_y           (in_point_y),
    .in_point_z           (in_point_z),
    .in_curve_param       (in_curve_param),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_curve_x          (out_curve_x),
    .out_curve_y          (out_curve_y),
    .out_curve_z          (out_curve_z)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2ms;
    $display("tb_top: FAIL");
    $finish;
  end

  function automatic longint horner_axis(longint p0, longint p1, longint p2, longint p3,
                                         longint u);
    longint a, b, c, d, r1, r2, r3;
    a  = -p0 + 3 * p1 - 3 * p2 + p3;
    b  = 2 * p0 - 5 * p1 + 4 * p2 - p3;
    c  = -p0 + p2;
    d  = 2 * p1;
    r1 = (a * u + b * 65536 + 32768) >>> 16;
    r2 = (r1 * u + c * 65536 + 32768) >>> 16;
    r3 = (r2 * u + d * 65536 + 65536) >>> 17;
    if (r3 > 64'sd2147483647) r3 = 64'sd2147483647;
    if (r3 < -64'sd2147483648) r3 = -64'sd2147483648;
    return r3;
  endfunction

  function automatic point_t curve_point(logic [PARAM_W-1:0] t_in);
    int     t, lst, scaled, seg, k;
    int     idx [4];
    longint u;
    point_t p;
    t      = (t_in > ONE_Q16) ? 65536 : int'(t_in);
    lst    = int'(last_index);
    scaled = t * lst;
    seg    = scaled >> 16;
    u      = scaled & 32'hFFFF;
    for (k = 0; k < 4; k++) begin
      idx[k] = seg - 1 + k;
      if (idx[k] < 0) idx[k] = 0;
      if (idx[k] > lst) idx[k] = lst;
    end
    p.x = coord_t'(horner_axis(point_table[idx[0]].x, point_table[idx[1]].x,
                               point_table[idx[2]].x, point_table[idx[3]].x, u));
    p.y = coord_t'(horner_axis(point_table[idx[0]].y, point_table[idx[1]].y,
                               point_table[idx[2]].y, point_table[idx[3]].y, u));
    p.z = coord_t'(horner_axis(point_table[idx[0]].z, point_table[idx[1]].z,
                               point_table[idx[2]].z, point_table[idx[3]].z, u));
    return p;
  endfunction

  function automatic coord_t rand_coord();
    case ($urandom_range(5))
      0:       return 32'sh7FFFFFFF;
      1:       return 32'sh80000000;
      2:       return 32'sd0;
      3:       return coord_t'($signed($urandom_range(8000000)) - 4000000);
      default: return coord_t'($urandom);
    endcase
  endfunction

  function automatic logic [PARAM_W-1:0] rand_param();
    case ($urandom_range(9))
      0:       return ONE_Q16;
      1:       return PARAM_W'($urandom);
      2:       return PARAM_W'($urandom_range(131071, 65537));
      default: return PARAM_W'($urandom_range(65535));
    endcase
  endfunction

  // Hold one word until taken; the model state advances at acceptance.
  task automatic send_word(logic act, logic [IDX_IN_W-1:0] slot, coord_t x, coord_t y,
                           coord_t z, logic [PARAM_W-1:0] t);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_action      <= act;
    in_point_index <= slot;
    in_point_x     <= x;
    in_point_y     <= y;
    in_point_z     <= z;
    in_curve_param <= t;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (act == ACT_WRITE) begin
      point_table[slot] = '{x: x, y: y, z: z};
    end else begin
      expected_points.insert(expected_points.size(), curve_point(t));
    end
  endtask

  task automatic eval_at(logic [PARAM_W-1:0] t);
    send_word(ACT_EVAL, IDX_IN_W'($urandom), rand_coord(), rand_coord(), rand_coord(), t);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (expected_points.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic set_last_index(logic [IDX_IN_W-1:0] v);
    drain();
    cfg_valid            <= 1'b1;
    cfg_last_point_index <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid  <= 1'b0;
    last_index = v;
  endtask

  task automatic test_load_table();
    int i;
    for (i = 0; i < NUM_SLOTS; i++) begin
      case (i)
        0:       send_word(ACT_WRITE, IDX_IN_W'(i), 32'sh7FFFFFFF, 32'sh80000000, 32'sd0,
                           '0);
        1:       send_word(ACT_WRITE, IDX_IN_W'(i), 32'sh80000000, 32'sh7FFFFFFF,
                           32'sh00010000, '1);
        2:       send_word(ACT_WRITE, IDX_IN_W'(i), 32'sh7FFFFFFF, 32'sh80000000,
                           -32'sh00010000, '0);
        default: send_word(ACT_WRITE, IDX_IN_W'(i), rand_coord(), rand_coord(),
                           rand_coord(), rand_param());
      endcase
    end
  endtask

  task automatic test_directed();
    eval_at('0);
    eval_at(ONE_Q16);
    eval_at('1);
    eval_at(PARAM_W'(32768));
    eval_at(PARAM_W'(1));
    eval_at(PARAM_W'(65535));
    // every index clamps to zero
    set_last_index('0);
    eval_at(PARAM_W'(40000));
    eval_at(ONE_Q16);
    set_last_index('1);
    eval_at('0);
    eval_at(ONE_Q16);
    eval_at(PARAM_W'(65537));
    eval_at(PARAM_W'(4369));
    eval_at(PARAM_W'(61166));
    eval_at(PARAM_W'(65535));
    set_last_index(IDX_IN_W'(2));
    eval_at(PARAM_W'(32768));
    eval_at(PARAM_W'(16384));
  endtask

  task automatic test_random(int unsigned n_items);
    int unsigned k;
    for (k = 0; k < n_items; k++) begin
      if (k % 110 == 109) set_last_index(IDX_IN_W'($urandom));
      // hold off until the pipe has emptied
      if (k % 250 == 125) drain();
      if ($urandom_range(99) < 70) eval_at(rand_param());
      else send_word(ACT_WRITE, IDX_IN_W'($urandom), rand_coord(), rand_coord(),
                     rand_coord(), PARAM_W'($urandom));
    end
    drain();
  endtask

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    point_t exp_p;
    if (rst_n && out_valid && out_ready) begin
      if (expected_points.size() == 0) begin
        $display("%0t: unexpected word x=%0d y=%0d z=%0d", $time,
                 out_curve_x, out_curve_y, out_curve_z);
        mismatch_count++;
      end else begin
        exp_p = expected_points.pop_front();
        if (out_curve_x !== exp_p.x) begin
          $display("%0t: curve_x expected %0d actual %0d", $time, exp_p.x, out_curve_x);
          mismatch_count++;
        end
        if (out_curve_y !== exp_p.y) begin
          $display("%0t: curve_y expected %0d actual %0d", $time, exp_p.y, out_curve_y);
          mismatch_count++;
        end
        if (out_curve_z !== exp_p.z) begin
          $display("%0t: curve_z expected %0d actual %0d", $time, exp_p.z, out_curve_z);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    mismatch_count       = 0;
    last_index           = 4'd1;
    send_idle_pct        = 15;
    recv_idle_pct        = 59;
    rst_n                <= 1'b0;
    cfg_valid            <= 1'b0;
    cfg_last_point_index <= '0;
    in_valid             <= 1'b0;
    in_action            <= ACT_WRITE;
    in_point_index       <= '0;
    in_point_x           <= '0;
    in_point_y           <= '0;
    in_point_z           <= '0;
    in_curve_param       <= '0;
    out_ready            <= 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_load_table();
    test_directed();
    set_last_index(IDX_IN_W'(15));
    eval_at(PARAM_W'(65535));
    eval_at(ONE_Q16);
    test_random(650);
    send_idle_pct = 59;
    recv_idle_pct = 15;
    test_random(650);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(650);
    if (mismatch_count == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
